@@ rtl/bsrm_pkg.sv @@
// Shared types and fixed widths of the bucketed sliding-window rate meter.
package bsrm_pkg;

	// Fixed field and state widths
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned TS_W      = 64;
	localparam int unsigned AMT_W     = 32;
	localparam int unsigned PERIOD_W  = 32;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned BKT_W     = 48;
	localparam int unsigned RATE_W    = 52;
	localparam int unsigned TOTAL_W   = 64;
	localparam int unsigned DIV_CNT_W = 6;

	// Reset value of the bucket period register
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd1000;

	// Item operation codes
	localparam logic [MODE_W-1:0] MODE_EVENT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_T,
		ST_EV_CALC,
		ST_ADV,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_Q_CALC,
		ST_Q_SUM,
		ST_DIV_R,
		ST_RESULT
	} state_t;

endpackage

@@ rtl/bsrm_ram.sv @@
// Generic single-port-write, registered-read RAM.
module bsrm_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/bucketed_sliding_rate_meter.sv @@
// Top level of the bucketed sliding-window rate meter.
// Sliding-window rate meter over a ring of NUM_BUCKETS time buckets held in a RAM with one
// valid bit per bucket (a bucket that is not valid reads as zero, so clears take no sweep).
// Items are handled one at a time. Every event or query first turns its timestamp into a
// bucket number with a restoring divider that retires one quotient bit per cycle. An event
// then advances the ring one bucket at a time over the buckets passed (at most NUM_BUCKETS),
// reads and writes the head bucket and loads the result; a query works out its window, sums
// its usable buckets, then makes a second pass through the same divider and loads the result
// (when no rate is due it goes from the window straight to the result). A clear item or an
// unused mode goes straight to the result, and the next item is taken in the cycle after the
// result is loaded. A finished result sits in the output register, so the next item is taken
// while it waits to be read.
module bucketed_sliding_rate_meter #(
	parameter int unsigned NUM_BUCKETS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [bsrm_pkg::PERIOD_W-1:0]      cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bsrm_pkg::MODE_W-1:0]        mode,
	input  logic [bsrm_pkg::TS_W-1:0]          timestamp,
	input  logic [bsrm_pkg::AMT_W-1:0]         amount,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bsrm_pkg::RATE_W-1:0]        rate,
	output logic [bsrm_pkg::TOTAL_W-1:0]       running_total,
	output logic                               rate_valid
);

	localparam int unsigned IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_BUCKETS + 1);
	localparam int unsigned SUM_W = bsrm_pkg::BKT_W + IDX_W;
	localparam int unsigned DEN_W = bsrm_pkg::PERIOD_W + CNT_W;
	localparam int unsigned TS_W  = bsrm_pkg::TS_W;
	localparam logic [IDX_W-1:0] NB_IDX = IDX_W'(NUM_BUCKETS - 1);
	localparam logic [CNT_W-1:0] NB_CNT = CNT_W'(NUM_BUCKETS);
	localparam logic [bsrm_pkg::TIME_W-1:0] NB_TIME = bsrm_pkg::TIME_W'(NUM_BUCKETS);

	bsrm_pkg::state_t state_q, state_d;

	// Architectural state
	logic [bsrm_pkg::PERIOD_W-1:0] period_q;
	logic [NUM_BUCKETS-1:0]        vld_q;
	logic [IDX_W-1:0]              head_q;
	logic [CNT_W-1:0]              filled_q;
	logic [bsrm_pkg::TIME_W-1:0]   last_q;
	logic [bsrm_pkg::TOTAL_W-1:0]  total_q;

	// Working registers
	logic [bsrm_pkg::MODE_W-1:0]   mode_q;
	logic [bsrm_pkg::AMT_W-1:0]    amt_q;
	logic [TS_W-1:0]               div_num_q;
	logic [DEN_W-1:0]              div_rem_q;
	logic [DEN_W-1:0]              div_den_q;
	logic [bsrm_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]              step_q;
	logic [CNT_W-1:0]              iss_q;
	logic [IDX_W-1:0]              rd_idx_q;
	logic                          pend_q;
	logic                          rvld_q;
	logic [SUM_W-1:0]              sum_q;
	logic [bsrm_pkg::RATE_W-1:0]   res_rate_q;
	logic                          res_vld_q;

	// Output register
	logic                          out_valid_q;
	logic [bsrm_pkg::RATE_W-1:0]   rate_q;
	logic [bsrm_pkg::TOTAL_W-1:0]  total_out_q;
	logic                          rate_valid_q;

	// Combinational helpers
	logic                          accept;
	logic                          clr_go;
	logic                          div_last;
	logic                          out_load;
	logic [bsrm_pkg::PERIOD_W-1:0] period_eff;
	logic [DEN_W:0]                rem_sh;
	logic                          rem_ge;
	logic [DEN_W-1:0]              rem_next;
	logic [TS_W-1:0]               num_next;
	logic [bsrm_pkg::TIME_W-1:0]   bkt_num;
	logic [bsrm_pkg::TIME_W-1:0]   gap;
	logic                          gap_big;
	logic [CNT_W-1:0]              gap_small;
	logic [CNT_W-1:0]              n_minus_d;
	logic [CNT_W-1:0]              f_cnt;
	logic [CNT_W-1:0]              fd_cnt;
	logic [DEN_W-1:0]              den_calc;
	logic                          q_ok;
	logic [IDX_W-1:0]              head_inc;
	logic [IDX_W-1:0]              rd_idx_dec;
	logic                          ram_wr_en;
	logic                          ram_rd_en;
	logic [IDX_W-1:0]              ram_rd_addr;
	logic [bsrm_pkg::BKT_W-1:0]    ram_rd_data;
	logic [bsrm_pkg::BKT_W:0]      bkt_add;
	logic [bsrm_pkg::BKT_W-1:0]    bkt_new;
	logic [bsrm_pkg::TOTAL_W:0]    tot_add;
	logic [bsrm_pkg::TOTAL_W-1:0]  tot_new;
	logic [bsrm_pkg::RATE_W-1:0]   rate_sat;

	assign in_ready      = (state_q == bsrm_pkg::ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign clr_go        = accept && (mode == bsrm_pkg::MODE_CLEAR);
	assign out_valid     = out_valid_q;
	assign rate          = rate_q;
	assign running_total = total_out_q;
	assign rate_valid    = rate_valid_q;

	// Zero period behaves as one
	assign period_eff = (period_q == '0) ? bsrm_pkg::PERIOD_W'(1) : period_q;

	// One restoring division step
	assign rem_sh   = {div_rem_q, div_num_q[TS_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, div_den_q});
	assign rem_next = rem_ge ? DEN_W'(rem_sh - {1'b0, div_den_q}) : rem_sh[DEN_W-1:0];
	assign num_next = {div_num_q[TS_W-2:0], rem_ge};
	assign div_last = (div_cnt_q == '1);

	// Bucket number and gap to the last event
	assign bkt_num   = div_num_q[bsrm_pkg::TIME_W-1:0];
	assign gap       = bkt_num - last_q;
	assign gap_big   = (gap >= NB_TIME);
	assign gap_small = gap[CNT_W-1:0];

	// Usable buckets and denominator of a query
	assign n_minus_d = NB_CNT - gap_small;
	assign f_cnt     = (n_minus_d < filled_q) ? n_minus_d : filled_q;
	assign fd_cnt    = f_cnt + gap_small;
	assign den_calc  = DEN_W'(fd_cnt) * DEN_W'(period_eff);
	assign q_ok      = (last_q != '0) && !gap_big && (f_cnt >= CNT_W'(2));

	// Ring pointer steps
	assign head_inc   = (head_q == NB_IDX) ? '0 : IDX_W'(head_q + 1'b1);
	assign rd_idx_dec = (rd_idx_q == '0) ? NB_IDX : IDX_W'(rd_idx_q - 1'b1);

	// Saturating updates of the head bucket and the running total
	assign bkt_add = {1'b0, (vld_q[head_q] ? ram_rd_data : '0)}
		+ (bsrm_pkg::BKT_W + 1)'(amt_q);
	assign bkt_new = bkt_add[bsrm_pkg::BKT_W] ? '1 : bkt_add[bsrm_pkg::BKT_W-1:0];
	assign tot_add = {1'b0, total_q} + (bsrm_pkg::TOTAL_W + 1)'(amt_q);
	assign tot_new = tot_add[bsrm_pkg::TOTAL_W] ? '1 : tot_add[bsrm_pkg::TOTAL_W-1:0];

	// Clamp the final quotient to the rate width
	assign rate_sat = (num_next[TS_W-1:bsrm_pkg::RATE_W] != '0) ? '1
		: num_next[bsrm_pkg::RATE_W-1:0];

	// Bucket RAM access
	assign ram_wr_en   = (state_q == bsrm_pkg::ST_ADD_WR);
	assign ram_rd_en   = (state_q == bsrm_pkg::ST_ADD_RD)
		|| ((state_q == bsrm_pkg::ST_Q_SUM) && (iss_q != '0));
	assign ram_rd_addr = (state_q == bsrm_pkg::ST_ADD_RD) ? head_q : rd_idx_q;
	assign out_load    = (state_q == bsrm_pkg::ST_RESULT) && (!out_valid_q || out_ready);

	bsrm_ram #(
		.WIDTH(bsrm_pkg::BKT_W),
		.DEPTH(NUM_BUCKETS)
	) u_bkt_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(head_q),
		.wr_data(bkt_new),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsrm_pkg::ST_IDLE: begin
				if (accept) begin
					if (mode == bsrm_pkg::MODE_EVENT || mode == bsrm_pkg::MODE_QUERY) begin
						state_d = bsrm_pkg::ST_DIV_T;
					end else begin
						state_d = bsrm_pkg::ST_RESULT;
					end
				end
			end
			bsrm_pkg::ST_DIV_T: begin
				if (div_last) begin
					state_d = (mode_q == bsrm_pkg::MODE_QUERY) ? bsrm_pkg::ST_Q_CALC
						: bsrm_pkg::ST_EV_CALC;
				end
			end
			bsrm_pkg::ST_EV_CALC: begin
				state_d = (last_q != '0 && gap != '0) ? bsrm_pkg::ST_ADV
					: bsrm_pkg::ST_ADD_RD;
			end
			bsrm_pkg::ST_ADV: begin
				if (step_q == CNT_W'(1)) begin
					state_d = bsrm_pkg::ST_ADD_RD;
				end
			end
			bsrm_pkg::ST_ADD_RD: state_d = bsrm_pkg::ST_ADD_WR;
			bsrm_pkg::ST_ADD_WR: state_d = bsrm_pkg::ST_RESULT;
			bsrm_pkg::ST_Q_CALC: begin
				state_d = q_ok ? bsrm_pkg::ST_Q_SUM : bsrm_pkg::ST_RESULT;
			end
			bsrm_pkg::ST_Q_SUM: begin
				if (iss_q == '0 && !pend_q) begin
					state_d = bsrm_pkg::ST_DIV_R;
				end
			end
			bsrm_pkg::ST_DIV_R: begin
				if (div_last) begin
					state_d = bsrm_pkg::ST_RESULT;
				end
			end
			bsrm_pkg::ST_RESULT: begin
				if (out_load) begin
					state_d = bsrm_pkg::ST_IDLE;
				end
			end
			default: state_d = bsrm_pkg::ST_IDLE;
		endcase
	end

	// Configuration, ring state, counters and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= bsrm_pkg::PERIOD_RST;
			vld_q       <= '0;
			head_q      <= '0;
			filled_q    <= CNT_W'(1);
			last_q      <= '0;
			total_q     <= '0;
			div_cnt_q   <= '0;
			step_q      <= '0;
			iss_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			// Drop the ring state and the running total on a clear item
			if (clr_go) begin
				vld_q    <= '0;
				head_q   <= '0;
				filled_q <= CNT_W'(1);
				last_q   <= '0;
				total_q  <= '0;
			end
			if (accept) begin
				div_cnt_q <= '0;
			end
			if (state_q == bsrm_pkg::ST_DIV_T || state_q == bsrm_pkg::ST_DIV_R) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (state_q == bsrm_pkg::ST_EV_CALC) begin
				step_q <= gap_big ? NB_CNT : gap_small;
			end
			// Advance the ring one bucket and drop its contents
			if (state_q == bsrm_pkg::ST_ADV) begin
				head_q          <= head_inc;
				vld_q[head_inc] <= 1'b0;
				filled_q        <= (filled_q == NB_CNT) ? NB_CNT : CNT_W'(filled_q + 1'b1);
				step_q          <= step_q - 1'b1;
			end
			if (state_q == bsrm_pkg::ST_ADD_WR) begin
				vld_q[head_q] <= 1'b1;
				total_q       <= tot_new;
				last_q        <= bkt_num;
			end
			if (state_q == bsrm_pkg::ST_Q_CALC) begin
				iss_q  <= f_cnt;
				pend_q <= 1'b0;
			end
			if (state_q == bsrm_pkg::ST_Q_SUM) begin
				pend_q <= (iss_q != '0);
				if (iss_q != '0) begin
					iss_q <= iss_q - 1'b1;
				end
			end
			if (state_q == bsrm_pkg::ST_Q_SUM && iss_q == '0 && !pend_q) begin
				div_cnt_q <= '0;
			end
			// Hold the result until it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload, divider, bucket sum and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode;
			amt_q      <= amount;
			div_num_q  <= timestamp;
			div_rem_q  <= '0;
			div_den_q  <= DEN_W'(period_eff);
			res_rate_q <= '0;
			res_vld_q  <= 1'b0;
		end
		if (state_q == bsrm_pkg::ST_DIV_T || state_q == bsrm_pkg::ST_DIV_R) begin
			div_num_q <= num_next;
			div_rem_q <= rem_next;
		end
		if (state_q == bsrm_pkg::ST_DIV_R && div_last) begin
			res_rate_q <= rate_sat;
			res_vld_q  <= 1'b1;
		end
		if (state_q == bsrm_pkg::ST_Q_CALC) begin
			sum_q     <= '0;
			rd_idx_q  <= head_q;
			div_den_q <= den_calc;
		end
		// Walk the ring backwards; read data lands in the following cycle
		if (state_q == bsrm_pkg::ST_Q_SUM) begin
			if (iss_q != '0) begin
				rd_idx_q <= rd_idx_dec;
				rvld_q   <= vld_q[rd_idx_q];
			end
			if (pend_q) begin
				sum_q <= sum_q + (rvld_q ? SUM_W'(ram_rd_data) : '0);
			end
			if (iss_q == '0 && !pend_q) begin
				div_num_q <= TS_W'(sum_q);
				div_rem_q <= '0;
			end
		end
		if (out_load) begin
			rate_q       <= res_rate_q;
			total_out_q  <= total_q;
			rate_valid_q <= res_vld_q;
		end
	end

	a_filled_range: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q != '0 && filled_q <= NB_CNT)
		else $error("filled count out of range");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NB_IDX)
		else $error("head index beyond ring");

	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rate_valid_q |-> rate_q == '0)
		else $error("nonzero rate without a valid query");

	a_total_drop: assert property (@(posedge clk) disable iff (!arst_n)
		total_q < $past(total_q) |-> $past(clr_go))
		else $error("running total fell without a clear item");

endmodule

@@ bench/tb_bucketed_sliding_rate_meter.sv @@
// Self-checking testbench for the bucketed sliding-window rate meter.
`timescale 1ns / 100ps

module tb_bucketed_sliding_rate_meter;

	localparam int unsigned NUM_BUCKETS    = 16;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned N_DIRECTED     = 23;
	localparam int unsigned N_PHASES       = 6;
	localparam logic [63:0] RATE_MAX       = (64'd1 << bsrm_pkg::RATE_W) - 64'd1;
	// The mode code that the block leaves unused
	localparam logic [bsrm_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [bsrm_pkg::MODE_W-1:0] mode;
		logic [bsrm_pkg::TS_W-1:0]   ts;
		logic [bsrm_pkg::AMT_W-1:0]  amt;
	} item_t;

	typedef struct packed {
		logic [bsrm_pkg::RATE_W-1:0]  rate;
		logic [bsrm_pkg::TOTAL_W-1:0] total;
		logic                         valid;
	} result_t;

	typedef struct packed {
		item_t   it;
		logic    pinned;
		result_t res;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [bsrm_pkg::PERIOD_W-1:0]  cfg_wr_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [bsrm_pkg::MODE_W-1:0]    mode = bsrm_pkg::MODE_EVENT;
	logic [bsrm_pkg::TS_W-1:0]      timestamp = '0;
	logic [bsrm_pkg::AMT_W-1:0]     amount = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [bsrm_pkg::RATE_W-1:0]    rate;
	logic [bsrm_pkg::TOTAL_W-1:0]   running_total;
	logic                           rate_valid;

	// Typed expectation that travels with a directed item
	logic                           pin_en = 1'b0;
	result_t                        pin_res = '0;

	// Meter state as the predictor sees it
	logic [bsrm_pkg::BKT_W-1:0]     bkt_sum [NUM_BUCKETS];
	int unsigned                    head_idx;
	int unsigned                    fill_cnt;
	logic [bsrm_pkg::TIME_W-1:0]    last_bkt;
	logic [bsrm_pkg::TOTAL_W-1:0]   total;
	logic [bsrm_pkg::PERIOD_W-1:0]  meter_period;

	result_t                        pending_results [$];
	int unsigned                    n_sent = 0;
	int unsigned                    n_done = 0;
	int unsigned                    err_count = 0;
	int unsigned                    idle_cycles = 0;

	// Stimulus side
	int unsigned                    burst_left = 0;
	logic [bsrm_pkg::PERIOD_W-1:0]  stim_period = bsrm_pkg::PERIOD_RST;
	logic [bsrm_pkg::TS_W-1:0]      ts_cur = '0;
	row_t                           dir_rows [N_DIRECTED];
	logic [bsrm_pkg::PERIOD_W-1:0]  phase_period [N_PHASES];
	int unsigned                    phase_items [N_PHASES];

	bucketed_sliding_rate_meter #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.timestamp    (timestamp),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rate         (rate),
		.running_total(running_total),
		.rate_valid   (rate_valid)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Return the meter to its empty state
	function automatic void meter_clear();
		foreach (bkt_sum[i]) bkt_sum[i] = '0;
		head_idx = 0;
		fill_cnt = 1;
		last_bkt = '0;
		total    = '0;
	endfunction

	// Apply one item to the meter state and return the result it produces
	function automatic result_t meter_step(input item_t it);
		result_t                     r;
		logic [63:0]                 eff, quo, win_sum, denom;
		logic [bsrm_pkg::TIME_W-1:0] bn, gap;
		logic [bsrm_pkg::BKT_W:0]    bsum;
		logic [bsrm_pkg::TOTAL_W:0]  tsum;
		int unsigned                 hd, steps, f;
		r = '0;
		eff = (meter_period == '0) ? 64'd1 : {32'd0, meter_period};
		quo = it.ts / eff;
		bn = quo[bsrm_pkg::TIME_W-1:0];
		gap = bn - last_bkt;
		case (it.mode)
			bsrm_pkg::MODE_EVENT: begin
				hd = head_idx;
				// advance the ring, clearing each bucket passed
				if (last_bkt != '0) begin
					steps = (gap < NUM_BUCKETS) ? gap : NUM_BUCKETS;
					for (int i = 0; i < steps; i++) begin
						if (fill_cnt < NUM_BUCKETS) fill_cnt++;
						hd = (hd + 1) % NUM_BUCKETS;
						bkt_sum[hd] = '0;
					end
				end
				head_idx = hd;
				bsum = {1'b0, bkt_sum[hd]}
					+ {{(bsrm_pkg::BKT_W+1-bsrm_pkg::AMT_W){1'b0}}, it.amt};
				bkt_sum[hd] = bsum[bsrm_pkg::BKT_W] ? '1 : bsum[bsrm_pkg::BKT_W-1:0];
				tsum = {1'b0, total}
					+ {{(bsrm_pkg::TOTAL_W+1-bsrm_pkg::AMT_W){1'b0}}, it.amt};
				total = tsum[bsrm_pkg::TOTAL_W] ? '1 : tsum[bsrm_pkg::TOTAL_W-1:0];
				last_bkt = bn;
			end
			bsrm_pkg::MODE_QUERY: begin
				// sum the usable buckets back from the head
				if (last_bkt != '0 && gap < NUM_BUCKETS) begin
					f = NUM_BUCKETS - gap;
					if (fill_cnt < f) f = fill_cnt;
					if (f >= 2) begin
						win_sum = '0;
						for (int i = 0; i < f; i++)
							win_sum += bkt_sum[(head_idx + NUM_BUCKETS - i) % NUM_BUCKETS];
						denom = 64'(f + gap) * eff;
						quo = win_sum / denom;
						r.rate  = (quo > RATE_MAX) ? RATE_MAX[bsrm_pkg::RATE_W-1:0]
							: quo[bsrm_pkg::RATE_W-1:0];
						r.valid = 1'b1;
					end
				end
			end
			bsrm_pkg::MODE_CLEAR: meter_clear();
			default: ;
		endcase
		r.total = total;
		return r;
	endfunction

	// Track config, predict accepted items, check returned results
	always @(posedge clk) begin : monitor
		result_t got, want;
		logic    moved;
		moved = 1'b0;
		if (!arst_n) begin
			meter_clear();
			meter_period = bsrm_pkg::PERIOD_RST;
		end else begin
			if (out_valid && out_ready) begin
				moved = 1'b1;
				n_done++;
				got = '{rate: rate, total: running_total, valid: rate_valid};
				if (pending_results.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: result with none expected: rate %h total %h valid %b",
							$realtime, got.rate, got.total, got.valid);
				end else begin
					want = pending_results.pop_front();
					if (got.rate !== want.rate || got.total !== want.total ||
							got.valid !== want.valid) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("%0t: result %0d mismatch", $realtime, n_done);
							$display("  expected rate %h total %h valid %b",
								want.rate, want.total, want.valid);
							$display("  actual   rate %h total %h valid %b",
								got.rate, got.total, got.valid);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				want = meter_step('{mode: mode, ts: timestamp, amt: amount});
				if (pin_en) want = pin_res;
				pending_results.push_back(want);
			end
			if (cfg_wr_en) meter_period = cfg_wr_data;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	// Stall the result side in regimes: always ready, coin flip, mostly stalled
	always @(posedge clk) begin : result_sink
		int unsigned rx_left, rx_mode;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("bucketed_sliding_rate_meter test failed");
		$finish;
	end

	function automatic row_t dir_row(input logic [bsrm_pkg::MODE_W-1:0] m,
			input logic [bsrm_pkg::TS_W-1:0] ts, input logic [bsrm_pkg::AMT_W-1:0] amt);
		return '{it: '{mode: m, ts: ts, amt: amt}, pinned: 1'b0, res: '0};
	endfunction

	function automatic row_t pinned_row(input logic [bsrm_pkg::MODE_W-1:0] m,
			input logic [bsrm_pkg::TS_W-1:0] ts, input logic [bsrm_pkg::AMT_W-1:0] amt,
			input logic [bsrm_pkg::TOTAL_W-1:0] tot);
		// Pinned rows all carry rate zero and no valid rate
		return '{it: '{mode: m, ts: ts, amt: amt}, pinned: 1'b1,
			res: '{rate: '0, total: tot, valid: 1'b0}};
	endfunction

	// Draw a random item: mostly steady time steps, some far jumps
	function automatic item_t rand_item();
		item_t       it;
		logic [63:0] p, step;
		int unsigned roll;
		p = (stim_period == '0) ? 64'd1 : {32'd0, stim_period};
		roll = $urandom_range(0, 99);
		it.mode = (roll < 55) ? bsrm_pkg::MODE_EVENT : (roll < 88) ? bsrm_pkg::MODE_QUERY :
			(roll < 93) ? bsrm_pkg::MODE_CLEAR : MODE_SPARE;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			it.ts = {$urandom, $urandom};
		end else begin
			step = (roll < 45) ? 64'd0 : (roll < 90) ? 64'($urandom_range(1, 3)) :
				64'($urandom_range(4, 20));
			ts_cur += step * p;
			it.ts = ts_cur + ({32'd0, $urandom} % p);
		end
		it.amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
		return it;
	endfunction

	// Present one item after an optional burst gap and hold it until taken
	task automatic send_item(input item_t it, input logic pin, input result_t pres);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		mode      <= it.mode;
		timestamp <= it.ts;
		amount    <= it.amt;
		pin_en    <= pin;
		pin_res   <= pres;
		n_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off until every sent item has returned its result
	task automatic settle();
		in_valid <= 1'b0;
		while (n_done != n_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_period(input logic [bsrm_pkg::PERIOD_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		stim_period = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset period of 1000
		dir_rows = '{
			pinned_row(bsrm_pkg::MODE_QUERY, 64'd5000, 32'd0, 64'd0),
			pinned_row(bsrm_pkg::MODE_EVENT, 64'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF),
			pinned_row(bsrm_pkg::MODE_QUERY, 64'd999, 32'd0, 64'hFFFF_FFFF),
			pinned_row(MODE_SPARE, '1, '1, 64'hFFFF_FFFF),
			pinned_row(bsrm_pkg::MODE_CLEAR, '1, '1, 64'd0),
			dir_row(bsrm_pkg::MODE_EVENT, 64'd1000, 32'h0001_0000),
			dir_row(bsrm_pkg::MODE_EVENT, 64'd2500, 32'h0002_0000),
			dir_row(bsrm_pkg::MODE_EVENT, 64'd2999, 32'hFFFF_FFFF),
			dir_row(bsrm_pkg::MODE_QUERY, 64'd3000, 32'd0),
			dir_row(bsrm_pkg::MODE_EVENT, 64'd5000, 32'd1),
			dir_row(bsrm_pkg::MODE_QUERY, 64'd5999, 32'd0),
			dir_row(bsrm_pkg::MODE_QUERY, 64'd20999, 32'd0),
			dir_row(bsrm_pkg::MODE_QUERY, 64'd21000, 32'd0),
			dir_row(bsrm_pkg::MODE_EVENT, 64'd100000, 32'h0000_8000),
			dir_row(bsrm_pkg::MODE_EVENT, 64'd50000, 32'd7),
			dir_row(bsrm_pkg::MODE_QUERY, 64'd40000, 32'd0),
			dir_row(bsrm_pkg::MODE_EVENT, '1, 32'hFFFF_FFFF),
			dir_row(bsrm_pkg::MODE_QUERY, '1, 32'd0),
			dir_row(bsrm_pkg::MODE_EVENT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555),
			dir_row(bsrm_pkg::MODE_EVENT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA),
			dir_row(bsrm_pkg::MODE_QUERY, 64'h5555_5555_5555_5555 + 64'd3000, 32'd0),
			pinned_row(bsrm_pkg::MODE_CLEAR, 64'd0, 32'd0, 64'd0),
			pinned_row(MODE_SPARE, 64'd0, 32'd0, 64'd0)
		};
		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].res);

		// Random phases, each under its own bucket period; zero acts as one
		phase_period = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'($urandom_range(2, 4000)),
			$urandom, bsrm_pkg::PERIOD_RST};
		phase_items  = '{80, 80, 60, 100, 80, 100};
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			write_period(phase_period[ph]);
			ts_cur = {$urandom, $urandom} >> $urandom_range(0, 63);
			for (int n = 0; n < phase_items[ph]; n++) begin
				// now and then drain the block completely before the next item
				if ($urandom_range(0, 49) == 0) settle();
				send_item(rand_item(), 1'b0, '0);
			end
		end

		settle();
		repeat (200) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("bucketed_sliding_rate_meter test passed");
		else
			$display("bucketed_sliding_rate_meter test failed");
		$finish;
	end

endmodule
